// File: rtl/dpl_pkg.sv
// Shared types, constants and the byte classifier for the decimal and operator lexer.
`timescale 1ns / 1ps

package dpl_pkg;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_GT   = 8'h3E;

    localparam logic [15:0] LEN_ONE  = 16'd1;
    localparam logic [15:0] LEN_TWO  = 16'd2;
    localparam logic [15:0] LEN_MAX  = 16'hFFFF;

    typedef enum logic [2:0] {
        CC_END,
        CC_SPACE,
        CC_DIGIT,
        CC_PAIR,
        CC_PUNCT,
        CC_BAD
    } t_char_class;

    typedef struct packed {
        logic [7:0]  ch;
        t_char_class cls;
    } t_char_beat;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_NUMBER,
        MODE_PENDING,
        MODE_ERROR
    } t_lex_mode;

    typedef enum logic [1:0] {
        TOK_NUM = 2'd0,
        TOK_OP  = 2'd1,
        TOK_END = 2'd2,
        TOK_BAD = 2'd3
    } t_tok_kind;

    typedef struct packed {
        t_tok_kind   kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [63:0] value;
        logic [7:0]  c1;
        logic [7:0]  c2;
        logic        last;
    } t_token;

    function automatic t_char_class classify(input logic [7:0] c);
        t_char_class r;
        if (c == CH_NUL) begin
            r = CC_END;
        end else if (c == CH_SP || (c >= 8'd9 && c <= 8'd13)) begin
            r = CC_SPACE;
        end else if (c >= 8'd48 && c <= 8'd57) begin
            r = CC_DIGIT;
        end else if (c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT) begin
            r = CC_PAIR;
        end else if ((c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
                     (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126)) begin
            r = CC_PUNCT;
        end else begin
            r = CC_BAD;
        end
        return r;
    endfunction

    function automatic t_token make_token(input t_tok_kind kind, input logic [15:0] start,
                                          input logic [15:0] len, input logic [63:0] value,
                                          input logic [7:0] c1, input logic [7:0] c2);
        t_token t;
        t.kind  = kind;
        t.start = start;
        t.len   = len;
        t.value = value;
        t.c1    = c1;
        t.c2    = c2;
        t.last  = 1'b0;
        return t;
    endfunction

endpackage

// File: rtl/dpl_fifo.sv
// Two-entry queue between the classifier front and the lexer back end.
`timescale 1ns / 1ps

module dpl_fifo #(
    parameter int WIDTH = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_head_valid,
    output logic [WIDTH-1:0] o_head
);

    logic [WIDTH-1:0] r_data [2];
    logic [WIDTH-1:0] n_data [2];
    logic [1:0]       r_cnt;
    logic [1:0]       n_cnt;
    logic [1:0]       kept;

    assign o_full       = (r_cnt == 2'd2);
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_data[0];

    always_comb begin
        n_data[0] = r_data[0];
        n_data[1] = r_data[1];
        kept      = r_cnt;
        if (i_pop) begin
            n_data[0] = r_data[1];
            kept      = r_cnt - 2'd1;
        end
        n_cnt = kept;
        // push only happens when not full, so the write slot is 0 or 1
        if (i_push) begin
            n_data[kept[0]] = i_data;
            n_cnt           = kept + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_data[0] <= n_data[0];
        r_data[1] <= n_data[1];
    end

endmodule

// File: rtl/dpl_front.sv
// Input side: takes one text byte per beat and tags it with its character class.
`timescale 1ns / 1ps

module dpl_front (
    input  logic                i_in_valid,
    input  logic [7:0]          i_text_byte,
    input  logic                i_queue_full,
    output logic                o_in_stall,
    output logic                o_push,
    output dpl_pkg::t_char_beat o_beat
);

    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

    always_comb begin
        o_beat.ch  = i_text_byte;
        o_beat.cls = dpl_pkg::classify(i_text_byte);
    end

endmodule

// File: rtl/dpl_back.sv
// Lexer back end: token state machine, number accumulator and two-slot result buffer.
`timescale 1ns / 1ps

module dpl_back #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_head_valid,
    input  dpl_pkg::t_char_beat i_head,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dpl_pkg::t_token     o_token
);

    localparam int DW = OFFSET_BITS + 17;
    localparam int EW = OFFSET_BITS + 16;

    dpl_pkg::t_lex_mode      r_mode, n_mode;
    logic [OFFSET_BITS-1:0]  r_pos, n_pos;
    logic [OFFSET_BITS-1:0]  r_start, n_start;
    logic [63:0]             r_acc, n_acc;
    logic [7:0]              r_pend, n_pend;

    dpl_pkg::t_token r_out0, r_out1, n_out0, n_out1;
    logic [1:0]      r_occ, n_occ;

    logic [OFFSET_BITS-1:0] pos_inc;
    logic [EW-1:0]          pos_ext, start_ext;
    logic [DW-1:0]          diff;
    logic [15:0]            span;
    logic [67:0]            prod;
    logic [63:0]            acc_next;
    logic [3:0]             digit;
    logic                   is_eq;
    logic                   proc_idle;

    logic            have_close, have_new;
    dpl_pkg::t_token tok_close, tok_new, res0, res1;
    logic [1:0]      nres;

    logic            out_pop;
    logic [1:0]      kept;
    dpl_pkg::t_token kept0;

    assign digit   = i_head.ch[3:0];
    assign is_eq   = (i_head.ch == dpl_pkg::CH_EQ);
    assign pos_inc = (r_pos == {OFFSET_BITS{1'b1}}) ? r_pos : r_pos + OFFSET_BITS'(1);

    assign pos_ext   = {16'b0, r_pos};
    assign start_ext = {16'b0, r_start};
    assign diff      = {17'b0, r_pos} - {17'b0, r_start};
    assign span      = (diff > DW'(dpl_pkg::LEN_MAX)) ? dpl_pkg::LEN_MAX : diff[15:0];

    // acc * 10 + d; any carry into the top nibble means overflow
    assign prod     = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + 68'(digit);
    assign acc_next = (|prod[67:64]) ? {64{1'b1}} : prod[63:0];

    assign proc_idle = (r_mode == dpl_pkg::MODE_IDLE) ||
                       (r_mode == dpl_pkg::MODE_NUMBER && i_head.cls != dpl_pkg::CC_DIGIT) ||
                       (r_mode == dpl_pkg::MODE_PENDING && !is_eq);

    // results produced by the head byte
    always_comb begin
        have_close = 1'b0;
        have_new   = 1'b0;
        tok_close  = dpl_pkg::make_token(dpl_pkg::TOK_OP, start_ext[15:0], dpl_pkg::LEN_ONE,
                                         64'd0, r_pend, 8'd0);
        tok_new    = dpl_pkg::make_token(dpl_pkg::TOK_OP, pos_ext[15:0], dpl_pkg::LEN_ONE,
                                         64'd0, i_head.ch, 8'd0);
        unique case (r_mode)
            dpl_pkg::MODE_NUMBER: begin
                if (i_head.cls != dpl_pkg::CC_DIGIT) begin
                    have_close = 1'b1;
                    tok_close  = dpl_pkg::make_token(dpl_pkg::TOK_NUM, start_ext[15:0], span,
                                                     r_acc, 8'd0, 8'd0);
                end
            end
            dpl_pkg::MODE_PENDING: begin
                have_close = 1'b1;
                if (is_eq) begin
                    tok_close = dpl_pkg::make_token(dpl_pkg::TOK_OP, start_ext[15:0],
                                                    dpl_pkg::LEN_TWO, 64'd0, r_pend,
                                                    i_head.ch);
                end
            end
            dpl_pkg::MODE_IDLE,
            dpl_pkg::MODE_ERROR: begin
            end
            default: begin
            end
        endcase
        if (proc_idle) begin
            unique case (i_head.cls)
                dpl_pkg::CC_END: begin
                    have_new = 1'b1;
                    tok_new  = dpl_pkg::make_token(dpl_pkg::TOK_END, pos_ext[15:0], 16'd0,
                                                   64'd0, 8'd0, 8'd0);
                end
                dpl_pkg::CC_PUNCT: begin
                    have_new = 1'b1;
                end
                dpl_pkg::CC_BAD: begin
                    have_new     = 1'b1;
                    tok_new.kind = dpl_pkg::TOK_BAD;
                end
                dpl_pkg::CC_SPACE,
                dpl_pkg::CC_DIGIT,
                dpl_pkg::CC_PAIR: begin
                end
                default: begin
                end
            endcase
        end
        res0 = have_close ? tok_close : tok_new;
        res1 = tok_new;
        nres = {1'b0, have_close} + {1'b0, have_new};
        if (nres == 2'd1) begin
            res0.last = 1'b1;
        end
        res1.last = 1'b1;
    end

    // only take the head once the result buffer can hold all of its tokens
    assign o_pop = i_head_valid && ({1'b0, r_occ} + {1'b0, nres} <= 3'd2);

    // next lexer state
    always_comb begin
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_start = r_start;
        n_acc   = r_acc;
        n_pend  = r_pend;
        if (o_pop) begin
            unique case (r_mode)
                dpl_pkg::MODE_ERROR: begin
                    if (i_head.cls == dpl_pkg::CC_END) begin
                        n_mode  = dpl_pkg::MODE_IDLE;
                        n_pos   = '0;
                        n_start = '0;
                        n_acc   = '0;
                        n_pend  = '0;
                    end
                end
                dpl_pkg::MODE_NUMBER: begin
                    if (i_head.cls == dpl_pkg::CC_DIGIT) begin
                        n_acc = acc_next;
                        n_pos = pos_inc;
                    end else begin
                        n_mode = dpl_pkg::MODE_IDLE;
                    end
                end
                dpl_pkg::MODE_PENDING: begin
                    n_mode = dpl_pkg::MODE_IDLE;
                    n_pend = '0;
                    if (is_eq) begin
                        n_pos = pos_inc;
                    end
                end
                dpl_pkg::MODE_IDLE: begin
                end
                default: begin
                end
            endcase
            if (proc_idle) begin
                unique case (i_head.cls)
                    dpl_pkg::CC_END: begin
                        n_mode  = dpl_pkg::MODE_IDLE;
                        n_pos   = '0;
                        n_start = '0;
                        n_acc   = '0;
                        n_pend  = '0;
                    end
                    dpl_pkg::CC_SPACE,
                    dpl_pkg::CC_PUNCT: begin
                        n_pos = pos_inc;
                    end
                    dpl_pkg::CC_DIGIT: begin
                        n_start = r_pos;
                        n_acc   = {60'd0, digit};
                        n_mode  = dpl_pkg::MODE_NUMBER;
                        n_pos   = pos_inc;
                    end
                    dpl_pkg::CC_PAIR: begin
                        n_start = r_pos;
                        n_pend  = i_head.ch;
                        n_mode  = dpl_pkg::MODE_PENDING;
                        n_pos   = pos_inc;
                    end
                    dpl_pkg::CC_BAD: begin
                        n_mode = dpl_pkg::MODE_ERROR;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // result buffer: slot 0 drives the port, slot 1 queues behind it
    assign o_out_valid = (r_occ != 2'd0);
    assign o_token     = r_out0;
    assign out_pop     = o_out_valid && !i_out_stall;

    always_comb begin
        kept0 = out_pop ? r_out1 : r_out0;
        kept  = r_occ - {1'b0, out_pop};
        n_out0 = (kept != 2'd0) ? kept0 : res0;
        if (kept == 2'd2) begin
            n_out1 = r_out1;
        end else if (kept == 2'd1) begin
            n_out1 = res0;
        end else begin
            n_out1 = res1;
        end
        n_occ = kept + (o_pop ? nres : 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= dpl_pkg::MODE_IDLE;
            r_pos   <= '0;
            r_start <= '0;
            r_acc   <= '0;
            r_pend  <= '0;
            r_occ   <= 2'd0;
        end else begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_acc   <= n_acc;
            r_pend  <= n_pend;
            r_occ   <= n_occ;
        end
        r_out0 <= n_out0;
        r_out1 <= n_out1;
    end

endmodule

// File: rtl/decimal_and_punct_lexer.sv
// Top level of the streaming decimal-number and operator lexer.
`timescale 1ns / 1ps

// Takes one source byte per beat (0 ends a text) and returns tokens: numbers with a
// saturating 64-bit value, one- and two-byte operators (==, !=, <=, >=), an end token,
// and an error token for an invalid byte, after which bytes are dropped until the next
// 0. Bytes enter a two-entry queue after classification; the back end takes one byte
// per cycle from it, while its two-slot output buffer has room for that byte's tokens.
// A byte is accepted every cycle while the output side keeps up; its first token is
// held in the queue register and then the output buffer register before it is shown.
// The port carries one token per beat; a byte that closes one token and starts another
// shows both in turn. Offsets use OFFSET_BITS saturating bits; 16 bits are reported.

module decimal_and_punct_lexer #(
    parameter int OFFSET_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_text_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_token_kind,
    output logic [15:0] o_start_offset,
    output logic [15:0] o_token_length,
    output logic [63:0] o_number_value,
    output logic [7:0]  o_first_char,
    output logic [7:0]  o_second_char,
    output logic        o_last_of_run
);

    localparam int BW = $bits(dpl_pkg::t_char_beat);

    dpl_pkg::t_char_beat push_beat;
    dpl_pkg::t_char_beat head_beat;
    dpl_pkg::t_token     token;
    logic                push;
    logic                pop;
    logic                queue_full;
    logic                head_valid;
    logic [BW-1:0]       head_bits;

    dpl_front u_front (
        .i_in_valid   (i_in_valid),
        .i_text_byte  (i_text_byte),
        .i_queue_full (queue_full),
        .o_in_stall   (o_in_stall),
        .o_push       (push),
        .o_beat       (push_beat)
    );

    dpl_fifo #(
        .WIDTH (BW)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_data       (push_beat),
        .i_pop        (pop),
        .o_full       (queue_full),
        .o_head_valid (head_valid),
        .o_head       (head_bits)
    );

    assign head_beat = head_bits;

    dpl_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head_beat),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_token      (token)
    );

    assign o_token_kind   = token.kind;
    assign o_start_offset = token.start;
    assign o_token_length = token.len;
    assign o_number_value = token.value;
    assign o_first_char   = token.c1;
    assign o_second_char  = token.c2;
    assign o_last_of_run  = token.last;

endmodule
